// ===== sv/hdgr_pkg.sv =====
// Shared types, constants and ROM functions for the humidity digit glyph renderer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package hdgr_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned CmdLen = 6;
  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] CmdLenPos = PosW'(CmdLen);
  localparam logic [PosW-1:0] LastPos = PosW'(29);

  localparam logic [7:0] CodeR = 8'h52;
  localparam logic [7:0] CodeE = 8'h45;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_R    = 2'd1,
    KIND_E    = 2'd2
  } hdgr_kind_e;

  // One classified request waiting for the back end.
  typedef struct packed {
    hdgr_kind_e  kind;
    logic [1:0]  hundreds;
    logic [3:0]  tens;
    logic [3:0]  ones;
  } hdgr_item_t;

  localparam logic [7:0] FontRom [10][8] = '{
    '{8'h00, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h81, 8'hFF, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'hF1, 8'h91, 8'h91, 8'h91, 8'h91, 8'h9F, 8'h00},
    '{8'h00, 8'h91, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00},
    '{8'h00, 8'h1F, 8'h10, 8'h10, 8'hFC, 8'h10, 8'h10, 8'h00},
    '{8'h00, 8'h9F, 8'h91, 8'h91, 8'h91, 8'h91, 8'hF1, 8'h00},
    '{8'h00, 8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'hF1, 8'h00},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'hFF, 8'h00},
    '{8'h00, 8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00},
    '{8'h00, 8'h8F, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00}
  };

  // Clamp to the last glyph for codes above nine.
  function automatic logic [7:0] font_row(logic [3:0] digit, logic [2:0] row);
    logic [3:0] g;
    g = (digit > 4'd9) ? 4'd9 : digit;
    return FontRom[g][row];
  endfunction

  // Page/column window command bytes; only the page start differs per row.
  function automatic logic [7:0] cmd_byte(hdgr_kind_e kind, logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h22;
      3'd1:    b = (kind == KIND_E) ? 8'h03 : 8'h00;
      3'd2:    b = 8'h00;
      3'd3:    b = 8'h21;
      3'd4:    b = 8'h18;
      3'd5:    b = 8'h38;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/hdgr_front.sv =====
// Front end: classify the sensor code and split the value into decimal digits.
// Depends on hdgr_pkg.
`timescale 1ns / 1ps

module hdgr_front (
  input  logic              [7:0] sensor_code_i,
  input  logic              [7:0] humidity_i,
  output hdgr_pkg::hdgr_item_t    item_o
);
  import hdgr_pkg::*;

  logic [1:0]  hundreds;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones_full;

  always_comb begin
    if (humidity_i >= 8'd200) begin
      hundreds = 2'd2;
      rem      = 7'(humidity_i - 8'd200);
    end else if (humidity_i >= 8'd100) begin
      hundreds = 2'd1;
      rem      = 7'(humidity_i - 8'd100);
    end else begin
      hundreds = 2'd0;
      rem      = humidity_i[6:0];
    end
    // rem < 100: divide by ten as multiply by 205 / 2048
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = 7'(tens) * 7'd10;
    ones_full = rem - tens_x10;
  end

  always_comb begin
    item_o.hundreds = hundreds;
    item_o.tens     = tens;
    item_o.ones     = ones_full[3:0];
    case (sensor_code_i)
      CodeR:   item_o.kind = KIND_R;
      CodeE:   item_o.kind = KIND_E;
      default: item_o.kind = KIND_NONE;
    endcase
  end

endmodule

// ===== sv/hdgr_fifo.sv =====
// Short request queue between front and back end.
// Depends on hdgr_pkg for the entry type.
`timescale 1ns / 1ps

module hdgr_fifo #(
  parameter int unsigned Depth = hdgr_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hdgr_pkg::hdgr_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output hdgr_pkg::hdgr_item_t head_o
);
  import hdgr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  hdgr_item_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

// ===== sv/hdgr_back.sv =====
// Back end: walk one request byte by byte into a registered output stage.
// Depends on hdgr_pkg for the entry type, command and font functions.
`timescale 1ns / 1ps

module hdgr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  hdgr_pkg::hdgr_item_t req_i,
  output logic                 req_pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic           [7:0] m_axis_tdata_o,
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);
  import hdgr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos;
  logic            active_q, active_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, byte_sel;
  logic            out_data_q, out_last_q;
  logic            advance, load, is_cmd, is_last;
  logic [PosW-1:0] off;
  logic [3:0]      digit;

  assign advance = !out_valid_q || m_axis_tready_i;
  assign load    = advance && req_valid_i;

  always_comb begin
    if (active_q) begin
      pos = pos_q;
    end else begin
      pos = (req_i.kind == KIND_NONE) ? CmdLenPos : '0;
    end
    is_cmd  = (pos < CmdLenPos);
    is_last = (pos == LastPos);
    off     = pos - CmdLenPos;
    case (off[4:3])
      2'd0:    digit = {2'b00, req_i.hundreds};
      2'd1:    digit = req_i.tens;
      default: digit = req_i.ones;
    endcase
    byte_sel = is_cmd ? cmd_byte(req_i.kind, pos[2:0]) : font_row(digit, off[2:0]);
  end

  always_comb begin
    pos_d       = pos_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = load;
    end
    if (load) begin
      pos_d    = pos + 1'b1;
      active_d = !is_last;
    end
  end

  assign req_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      out_data_q <= !is_cmd;
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_data_q)
    else $error("final byte of a run is not pixel data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q >= 5'd1 && pos_q <= LastPos))
    else $error("byte position out of range mid-run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> (!active_q && out_last_q && out_valid_q))
    else $error("request dropped without a marked last byte");

endmodule

// ===== sv/humidity_digit_glyph_renderer.sv =====
// Top level of the humidity digit glyph renderer: front end, request queue, back end.
// Depends on hdgr_pkg, hdgr_front, hdgr_fifo and hdgr_back.
`timescale 1ns / 1ps

// Usage
// - Slave stream: one request per accepted beat (tvalid & tready), carrying a
//   sensor code and an 8-bit humidity value.
// - Master stream: one display byte per beat. tuser is the data/command line
//   level (1 pixel data, 0 command), tlast marks the last byte of a request.
// - Code 'R' or 'E' produces 6 window command bytes, then 24 glyph bytes
//   (hundreds, tens, ones; 8 font rows each). Other codes give only the 24.
// - A request passes through the queue and then the back end's output register
//   before its first byte shows on the master side.
// - Throughput: one output byte per cycle while the receiver keeps tready high;
//   set by the back end's byte sequencer.
// - The front end classifies and splits digits in the accept cycle and
//   pushes into a QueueDepth-entry queue, so requests are taken while the
//   back end still emits earlier ones; tready drops only when the queue fills.
// - Receiver stall: the output register holds its byte and the sequencer
//   waits; the request being emitted keeps its queue entry until its last
//   byte, so the queue absorbs up to QueueDepth - 1 further requests.
// - Reset: clears queue pointers, the sequencer and the output valid; no
//   byte is presented until a request arrives.

module humidity_digit_glyph_renderer #(
  parameter int unsigned QueueDepth = hdgr_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] sensor_code, [15:8] humidity
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic  [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tuser_o,   // [0] is_data
  output logic        m_axis_tlast_o    // last_of_run
);
  import hdgr_pkg::*;

  hdgr_item_t front_item;
  hdgr_item_t head_item;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;

  // Classify the request and split the value into digits.
  hdgr_front u_front (
    .sensor_code_i (s_axis_tdata_i[7:0]),
    .humidity_i    (s_axis_tdata_i[15:8]),
    .item_o        (front_item)
  );

  // Take a request whenever the queue has room.
  assign s_axis_tready_o = !queue_full;

  hdgr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .head_o      (head_item)
  );

  // Emit command and glyph bytes for the head request; pop it on its last byte.
  hdgr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (queue_valid),
    .req_i           (head_item),
    .req_pop_o       (queue_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== dv/tb_humidity_digit_glyph_renderer.sv =====
// Self-checking testbench for humidity_digit_glyph_renderer: drives sensor readings on the
// slave stream and checks every display byte against a predicted byte sequence.
// Depends on hdgr_pkg and the humidity_digit_glyph_renderer RTL.
`timescale 1ns / 1ps

module tb_humidity_digit_glyph_renderer;
  import hdgr_pkg::*;

  localparam int unsigned RandomRequests = 190;
  localparam int unsigned DrainCycles = 40;

  // One display byte as it should leave the master stream.
  typedef struct {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  // Holds the bytes each accepted request must produce, oldest first.
  class display_byte_scoreboard;
    panel_byte_t expected_bytes[$];
    int unsigned faults;
    logic [7:0]  glyph_rows[10][8];

    function new();
      faults = 0;
      glyph_rows = '{
        '{8'h00, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h81, 8'hFF, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'hF1, 8'h91, 8'h91, 8'h91, 8'h91, 8'h9F, 8'h00},
        '{8'h00, 8'h91, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00},
        '{8'h00, 8'h1F, 8'h10, 8'h10, 8'hFC, 8'h10, 8'h10, 8'h00},
        '{8'h00, 8'h9F, 8'h91, 8'h91, 8'h91, 8'h91, 8'hF1, 8'h00},
        '{8'h00, 8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'hF1, 8'h00},
        '{8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'hFF, 8'h00},
        '{8'h00, 8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00},
        '{8'h00, 8'h8F, 8'h91, 8'h91, 8'h91, 8'h91, 8'hFF, 8'h00}
      };
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Render one reading: optional window commands, then three glyphs, hundreds first.
    function void note_reading(logic [7:0] code, logic [7:0] humidity);
      hdgr_kind_e  kind;
      logic [7:0]  window[6];
      int unsigned digit[3];
      int unsigned total;
      int unsigned idx;
      panel_byte_t b;
      if (code == CodeR) kind = KIND_R;
      else if (code == CodeE) kind = KIND_E;
      else kind = KIND_NONE;
      total = (kind == KIND_NONE) ? 24 : 30;
      idx = 0;
      // Only the page start byte differs between the two rows.
      window = '{8'h22, (kind == KIND_E) ? 8'h03 : 8'h00, 8'h00, 8'h21, 8'h18, 8'h38};
      if (kind != KIND_NONE) begin
        for (int i = 0; i < 6; i++) begin
          b.out_byte = window[i];
          b.is_data = 1'b0;
          b.last = (idx == total - 1);
          expected_bytes.push_back(b);
          idx++;
        end
      end
      digit[0] = humidity / 100;
      digit[1] = (humidity / 10) % 10;
      digit[2] = humidity % 10;
      for (int d = 0; d < 3; d++) begin
        for (int r = 0; r < 8; r++) begin
          b.out_byte = glyph_rows[digit[d]][r];
          b.is_data = 1'b1;
          b.last = (idx == total - 1);
          expected_bytes.push_back(b);
          idx++;
        end
      end
    endfunction

    function void check_byte(logic [7:0] out_byte, logic is_data, logic last);
      panel_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected display byte %h (is_data %b, last %b)", out_byte, is_data, last);
        faults++;
        return;
      end
      want = expected_bytes.pop_front();
      if (out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, out_byte);
        faults++;
      end
      if (is_data !== want.is_data) begin
        $error("is_data: expected %b, got %b", want.is_data, is_data);
        faults++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = 16'h0000;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic  [7:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  logic        sender_calm = 1'b0;
  logic        receiver_calm = 1'b0;

  display_byte_scoreboard board = new();

  humidity_digit_glyph_renderer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),          // [7:0] sensor_code, [15:8] humidity
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] is_data
    .m_axis_tlast_o  (m_axis_tlast_o)    // last_of_run
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one request after a random gap; hold it until the block takes it.
  // A zero gap keeps tvalid high straight into the next request.
  task automatic send_request(logic [7:0] code, logic [7:0] humidity);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) sender_calm = ~sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {humidity, code};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_reading(code, humidity);
  endtask

  // Receiver: hold tready low for a random stall before each byte, then take and check it.
  initial begin : display_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) receiver_calm = ~receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      board.check_byte(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  initial begin : reading_source
    logic [7:0] code;
    int unsigned pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: both windows, unknown codes, digit extremes, bit patterns.
    send_request(CodeR, 8'd0);
    send_request(CodeE, 8'd255);
    send_request(8'h00, 8'd100);
    send_request(8'hFF, 8'd99);
    send_request(CodeR, 8'd199);
    send_request(CodeE, 8'd200);
    send_request(8'h41, 8'd9);
    send_request(8'h53, 8'd10);
    send_request(CodeR, 8'd123);
    send_request(CodeE, 8'd45);
    send_request(8'h44, 8'd67);
    send_request(8'h46, 8'd89);
    send_request(CodeR, 8'd255);
    send_request(CodeE, 8'd0);
    send_request(8'h51, 8'h55);
    send_request(8'hAA, 8'hAA);
    send_request(8'h55, 8'h55);
    send_request(CodeR, 8'd150);
    send_request(CodeE, 8'd208);
    send_request(8'h7F, 8'd111);
    send_request(8'h80, 8'd250);

    // Random: mostly real sensor codes, the rest any byte.
    for (int n = 0; n < RandomRequests; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) code = CodeR;
      else if (pick < 7) code = CodeE;
      else code = 8'($urandom_range(0, 255));
      send_request(code, 8'($urandom_range(0, 255)));
    end
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray bytes.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
